### design/abac_pkg.sv
package abac_pkg;

  localparam int CMD_W    = 2;
  localparam int LEN_W    = 9;
  localparam int OID_W    = 8;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 8;
  localparam int GID_W    = 8;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_IDS    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_FREE,
    S_COMPACT,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    CH_HOLD,
    CH_ROTATE,
    CH_SWAP
  } chain_mode_t;

  typedef struct packed {
    chain_mode_t mode;
    logic        parity;
  } chain_ctrl_t;

endpackage

### design/abac_cell.sv
module abac_cell import abac_pkg::*; #(
  parameter int IDW       = 8,
  parameter bit ODD       = 1'b0,
  parameter bit HAS_LEFT  = 1'b1,
  parameter bit HAS_RIGHT = 1'b1
) (
  input  logic           clk,
  input  logic           rst,
  input  chain_ctrl_t    ctrl,
  input  logic [IDW-1:0] left,
  input  logic [IDW-1:0] right,
  output logic [IDW-1:0] q
);

  logic [IDW-1:0] q_next;

  always_comb begin
    unique case (ctrl.mode)
      CH_HOLD:   q_next = q;
      CH_ROTATE: q_next = right;
      CH_SWAP: begin
        if (HAS_RIGHT && (ctrl.parity == ODD) && (q == '0) && (right != '0)) begin
          q_next = right;
        end else if (HAS_LEFT && (ctrl.parity != ODD) && (left == '0) && (q != '0)) begin
          q_next = left;
        end else begin
          q_next = q;
        end
      end
      default:   q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

### design/abac_chain.sv
module abac_chain import abac_pkg::*; #(
  parameter int N   = 256,
  parameter int IDW = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  chain_ctrl_t    ctrl,
  input  logic [IDW-1:0] tail_in,
  output logic [IDW-1:0] head
);

  logic [IDW-1:0] q [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [IDW-1:0] left_v;
    logic [IDW-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = q[i-1];
    end
    if (i == N-1) begin : g_last
      assign right_v = tail_in;
    end else begin : g_mid_r
      assign right_v = q[i+1];
    end
    abac_cell #(
      .IDW(IDW),
      .ODD(i % 2 == 1),
      .HAS_LEFT(i != 0),
      .HAS_RIGHT(i != N-1)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctrl(ctrl),
      .left(left_v),
      .right(right_v),
      .q(q[i])
    );
  end

  assign head = q[0];

endmodule

### design/aligned_block_allocator_compactor_core.sv
// Power-of-two aligned block allocator over a rotating chain of owner cells.
// Each command is one transaction in and one result transaction out. Cell
// memory is a ring of MEM_CELLS registers that rotates past a single head
// cell, so every scan visits all cells in address order. Allocate takes two
// full passes (one pass when no window fits), free takes one pass, even when
// the id is not live, and compact takes one pass of odd-even neighbor swaps.
// An allocate with no ids left, a free of id zero and the unused command
// make no pass and go straight to the result. A new command is accepted
// only after the previous one has finished, while its result may still wait
// at the output register.
module aligned_block_allocator_compactor_core import abac_pkg::*; #(
  parameter int MEM_CELLS = 256,
  parameter int MAX_IDS   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // cmd[1:0], req_length[10:2], owner_id[18:11]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[1:0], start_addr[9:2], given_id[17:10]
);

  localparam int CW  = $clog2(MEM_CELLS);
  localparam int IDW = $clog2(MAX_IDS);
  localparam int EW  = (CW > LEN_W) ? CW : LEN_W;

  state_t state, state_next;

  logic [CW-1:0]       addr;
  logic [LEN_W-1:0]    len_eff;
  logic [LEN_W-1:0]    win_mask;
  logic [IDW-1:0]      id_sel;
  logic [IDW-1:0]      id_counter;
  logic                win_ok;
  logic                found;
  logic [CW-1:0]       found_addr;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_start;
  logic [GID_W-1:0]    res_id;

  logic [CMD_W-1:0] in_cmd;
  logic [LEN_W-1:0] in_len;
  logic [OID_W-1:0] in_oid;
  logic [LEN_W-1:0] in_len_eff;
  logic [LEN_W-1:0] smear;

  chain_ctrl_t    ctrl;
  logic [IDW-1:0] head;
  logic [IDW-1:0] tail_in;

  logic          accept;
  logic          pass_end;
  logic          out_free;
  logic [EW-1:0] addr_ext;
  logic [EW-1:0] lo;
  logic          win_ok_now;
  logic          win_end;
  logic [CW-1:0] offset;
  logic          fill_hit;
  logic          free_hit;

  assign in_cmd = s_tdata[1:0];
  assign in_len = s_tdata[10:2];
  assign in_oid = s_tdata[18:11];

  assign in_len_eff = (in_len == '0) ? LEN_W'(1) : in_len;

  always_comb begin
    smear = in_len_eff - LEN_W'(1);
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
  end

  assign accept   = s_tvalid && s_tready;
  assign pass_end = (addr == CW'(MEM_CELLS - 1));
  assign out_free = !m_tvalid || m_tready;

  assign addr_ext   = EW'(addr);
  assign lo         = addr_ext & EW'(win_mask);
  assign win_ok_now = ((lo == '0) || win_ok) && (head == '0);
  assign win_end    = (lo == EW'(win_mask));
  assign offset     = addr - found_addr;
  assign fill_hit   = (addr >= found_addr) && (EW'(offset) < EW'(len_eff));
  assign free_hit   = (head == id_sel);

  abac_chain #(
    .N(MEM_CELLS),
    .IDW(IDW)
  ) u_chain (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .tail_in(tail_in),
    .head(head)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (in_cmd == CMD_ALLOC) begin
            state_next = (id_counter >= IDW'(MAX_IDS - 1)) ? S_FINISH : S_SCAN;
          end else if (in_cmd == CMD_FREE) begin
            state_next = ((in_oid == '0) || (32'(in_oid) >= MAX_IDS)) ? S_FINISH : S_FREE;
          end else if (in_cmd == CMD_COMPACT) begin
            state_next = S_COMPACT;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (pass_end) begin
          state_next = (found || (win_end && win_ok_now)) ? S_FILL : S_FINISH;
        end
      end
      S_FILL, S_FREE, S_COMPACT: begin
        if (pass_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = (state == S_IDLE);
    ctrl.parity = addr[0];
    ctrl.mode   = CH_HOLD;
    tail_in     = head;
    unique case (state)
      S_SCAN:    ctrl.mode = CH_ROTATE;
      S_FILL: begin
        ctrl.mode = CH_ROTATE;
        tail_in   = fill_hit ? id_sel : head;
      end
      S_FREE: begin
        ctrl.mode = CH_ROTATE;
        tail_in   = free_hit ? '0 : head;
      end
      S_COMPACT: ctrl.mode = CH_SWAP;
      default:   ctrl.mode = CH_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      addr       <= '0;
      id_counter <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_FINISH) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          addr   <= '0;
          found  <= 1'b0;
          win_ok <= 1'b0;
          if (accept) begin
            len_eff    <= in_len_eff;
            win_mask   <= smear;
            res_status <= ST_OK;
            res_start  <= '0;
            res_id     <= '0;
            id_sel     <= IDW'(in_oid);
            if (in_cmd == CMD_ALLOC) begin
              if (id_counter >= IDW'(MAX_IDS - 1)) begin
                res_status <= ST_NO_IDS;
              end else begin
                id_counter <= id_counter + IDW'(1);
                id_sel     <= id_counter + IDW'(1);
              end
            end else if (in_cmd == CMD_FREE) begin
              res_status <= ST_NOT_FOUND;
            end
          end
        end
        S_SCAN: begin
          win_ok <= win_ok_now;
          if (win_end && win_ok_now && !found) begin
            found      <= 1'b1;
            found_addr <= addr - CW'(lo);
          end
          if (pass_end) begin
            addr <= '0;
            if (!(found || (win_end && win_ok_now))) begin
              res_status <= ST_NO_SPACE;
            end
          end else begin
            addr <= addr + CW'(1);
          end
        end
        S_FILL: begin
          if (pass_end) begin
            res_start <= ADDR_W'(found_addr);
            res_id    <= GID_W'(id_sel);
          end
          addr <= pass_end ? '0 : addr + CW'(1);
        end
        S_FREE: begin
          if (free_hit && !found) begin
            found      <= 1'b1;
            res_status <= ST_OK;
            res_start  <= ADDR_W'(addr);
          end
          addr <= pass_end ? '0 : addr + CW'(1);
        end
        S_COMPACT: begin
          addr <= pass_end ? '0 : addr + CW'(1);
        end
        S_FINISH: begin
          if (out_free) begin
            m_tdata <= {6'd0, res_id, res_start, res_status};
          end
        end
        default: begin
          addr <= '0;
        end
      endcase
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command accepted while another is in progress");

  a_id_range: assert property (@(posedge clk) disable iff (rst)
    id_counter <= IDW'(MAX_IDS - 1))
    else $error("id counter beyond last id");

  a_fail_no_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[17:10] == '0))
    else $error("failed result carries an id");

endmodule
